// ===== rtl/snfr_pkg.sv =====
`default_nettype none

package snfr_pkg;

  localparam int NumDigits  = 10;   // decimal digits of a 32-bit magnitude
  localparam int MaxChars   = 11;   // minus sign plus ten digits
  localparam int ConvSteps  = 32;   // one input bit per double-dabble step
  localparam int CharPitch  = 11;   // pixels from one character to the next
  localparam int LaneCount  = 8;    // frame bytes per output word
  localparam int WordsOut   = 64;

  typedef logic [3:0] char_code_t;

  localparam char_code_t CharMinus = 4'd10;
  localparam char_code_t CharBlank = 4'd15;

  // frame pages: text only ever lands in pages 1 and 2 (y 8..23)
  localparam logic [1:0] PageUpper = 2'd1;
  localparam logic [1:0] PageLower = 2'd2;

  // 5x8 font, column col of glyph code; bit r is row r
  function automatic logic [7:0] glyph_col(input char_code_t code, input logic [2:0] col);
    logic [39:0] g;
    logic [7:0]  c;
    case (code)
      4'd0:      g = 40'h3E_51_49_45_3E;
      4'd1:      g = 40'h00_42_7F_40_00;
      4'd2:      g = 40'h62_51_49_49_46;
      4'd3:      g = 40'h22_49_49_49_36;
      4'd4:      g = 40'h18_14_12_7F_10;
      4'd5:      g = 40'h2F_49_49_49_31;
      4'd6:      g = 40'h3E_49_49_49_30;
      4'd7:      g = 40'h01_71_09_05_03;
      4'd8:      g = 40'h36_49_49_49_36;
      4'd9:      g = 40'h06_49_49_29_1E;
      CharMinus: g = 40'h08_08_08_08_08;
      default:   g = 40'h0;
    endcase
    case (col)
      3'd0:    c = g[39:32];
      3'd1:    c = g[31:24];
      3'd2:    c = g[23:16];
      3'd3:    c = g[15:8];
      3'd4:    c = g[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // vertical 2x scale: each glyph row covers two frame bits
  function automatic logic [7:0] dbl_rows(input logic [3:0] n);
    return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scaled_number_framebuffer_render.sv =====
`default_nettype none

// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_stall   in_value (signed 32)
// out      out  out_valid/out_stall out_pixel_word, out_word_index, out_last
//
// One item: an accept, 32 double-dabble steps (shared BCD shift/adjust
// unit), a normalize pass (0..9 leading-zero strips), a layout step, then
// 64 words at one per cycle while out_stall stays low.
// in_stall is high from accept until the last word is loaded into the output
// register. rst_n is synchronous; it clears the sequencer and out_valid.
// out_stall holds the output register and pauses the word walk.
module scaled_number_framebuffer_render (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [31:0] in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [63:0]            out_pixel_word,
  output logic [5:0]             out_word_index,
  output logic                   out_last
);
  import snfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_PREP,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        bin_r, bin_nxt;          // magnitude, shifted out msb first
  logic [39:0]        bcd_r, bcd_nxt;          // ten BCD digits, most significant on top
  logic [4:0]         step_r, step_nxt;
  logic [3:0]         nd_r, nd_nxt;            // significant digit count
  logic signed [6:0]  off_start_r, off_start_nxt;
  logic signed [6:0]  off_r, off_nxt;          // lane 0 column relative to current char
  char_code_t         base_r [MaxChars];
  char_code_t         base_nxt [MaxChars];
  char_code_t         chars_r [MaxChars];      // shift line, head is the current char
  char_code_t         chars_nxt [MaxChars];
  logic [5:0]         k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_pixel_word_r, out_pixel_word_nxt;
  logic [5:0]         out_word_index_r, out_word_index_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic               emit_go;
  logic [39:0]        bcd_adj;
  logic [3:0]         len_c;
  logic [7:0]         len_x11;
  logic signed [7:0]  off8;
  logic [63:0]        word_c;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // double-dabble add-3 on each digit before the shift
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                     : bcd_r[4*d +: 4];
    end
  end

  // text layout: start x = (129 - 11*len) / 2, lane offset starts at -x
  assign len_c   = nd_r + {3'b000, neg_r};
  assign len_x11 = 8'({4'b0000, len_c} * 8'd11);

  // eight lanes of the current word; at most one char boundary inside a word
  always_comb begin
    logic signed [7:0] o;
    logic signed [7:0] oc;
    char_code_t        code;
    logic [7:0]        g;
    word_c = '0;
    for (int j = 0; j < LaneCount; j++) begin
      o = 8'(off_r) + 8'(j);
      if (o >= 8'sd11) begin
        code = chars_r[1];
        oc   = o - 8'sd11;
      end else begin
        code = chars_r[0];
        oc   = o;
      end
      g = 8'h00;
      if (o >= 8'sd0 && oc != 8'sd10 && code != CharBlank) begin
        g = glyph_col(code, oc[3:1]);   // horizontal 2x scale
      end
      if (k_r[5:4] == PageUpper) begin
        word_c[8*j +: 8] = dbl_rows(g[3:0]);
      end else if (k_r[5:4] == PageLower) begin
        word_c[8*j +: 8] = dbl_rows(g[7:4]);
      end
    end
  end

  assign off8 = 8'(off_r) + 8'sd8;

  always_comb begin
    state_nxt          = state_r;
    neg_nxt            = neg_r;
    bin_nxt            = bin_r;
    bcd_nxt            = bcd_r;
    step_nxt           = step_r;
    nd_nxt             = nd_r;
    off_start_nxt      = off_start_r;
    off_nxt            = off_r;
    base_nxt           = base_r;
    chars_nxt          = chars_r;
    k_nxt              = k_r;
    out_valid_nxt      = out_valid_r;
    out_pixel_word_nxt = out_pixel_word_r;
    out_word_index_nxt = out_word_index_r;
    out_last_nxt       = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt   = in_value[31];
          bin_nxt   = in_value[31] ? (~in_value + 32'd1) : in_value;
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt  = {bcd_adj[38:0], bin_r[31]};
        bin_nxt  = {bin_r[30:0], 1'b0};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(ConvSteps - 1)) begin
          nd_nxt    = 4'(NumDigits);
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // strip leading zeros, keep at least one digit
        if (bcd_r[39:36] == 4'd0 && nd_r > 4'd1) begin
          bcd_nxt = {bcd_r[35:0], 4'd0};
          nd_nxt  = nd_r - 4'd1;
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        for (int i = 0; i < MaxChars; i++) begin
          base_nxt[i] = CharBlank;
          if (neg_r) begin
            if (i == 0) begin
              base_nxt[i] = CharMinus;
            end else if (4'(i - 1) < nd_r) begin
              base_nxt[i] = bcd_r[39 - 4*((i + NumDigits - 1) % NumDigits) -: 4];
            end
          end else if (i < NumDigits && 4'(i) < nd_r) begin
            base_nxt[i] = bcd_r[39 - 4*(i % NumDigits) -: 4];
          end
        end
        chars_nxt     = base_nxt;
        off_start_nxt = 7'(8'd0 - ((8'd129 - len_x11) >> 1));
        off_nxt       = off_start_nxt;
        k_nxt         = '0;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt      = 1'b1;
          out_pixel_word_nxt = word_c;
          out_word_index_nxt = k_r;
          out_last_nxt       = (k_r == 6'(WordsOut - 1));
          k_nxt              = k_r + 6'd1;
          if (k_r == 6'd31) begin
            // rewind the column walk for the lower page
            off_nxt   = off_start_r;
            chars_nxt = base_r;
          end else if (k_r[5:4] == PageUpper || k_r[5:4] == PageLower) begin
            if (off8 >= 8'sd11) begin
              off_nxt = 7'(off8 - 8'sd11);
              for (int i = 0; i < MaxChars - 1; i++) begin
                chars_nxt[i] = chars_r[i+1];
              end
              chars_nxt[MaxChars-1] = CharBlank;
            end else begin
              off_nxt = 7'(off8);
            end
          end
          if (k_r == 6'(WordsOut - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      k_r         <= '0;
      nd_r        <= 4'd1;
      off_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
      nd_r        <= nd_nxt;
      off_r       <= off_nxt;
    end
    neg_r            <= neg_nxt;
    bin_r            <= bin_nxt;
    bcd_r            <= bcd_nxt;
    off_start_r      <= off_start_nxt;
    base_r           <= base_nxt;
    chars_r          <= chars_nxt;
    out_pixel_word_r <= out_pixel_word_nxt;
    out_word_index_r <= out_word_index_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_word = out_pixel_word_r;
  assign out_word_index = out_word_index_r;
  assign out_last       = out_last_r;

  a_acc_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_CONV)
    else $error("accepted item did not start conversion");

  a_blank_pages: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word_index[5:4] == 2'd0 || out_word_index[5:4] == 2'd3)
      |-> out_pixel_word == 64'd0)
    else $error("pixels outside text pages");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_word_index == 6'd63)))
    else $error("last flag mismatch");

  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> off_r <= 7'sd10)
    else $error("column offset out of range");

  a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PREP |-> (nd_r >= 4'd1 && nd_r <= 4'd10))
    else $error("digit count out of range");

endmodule

`default_nettype wire

// ===== bench/scaled_number_framebuffer_render_tb.sv =====
// Frame predictor and word checker for the scaled number renderer.
class number_frame_checker;
  typedef struct {
    logic [63:0] pixel_word;
    logic [5:0]  word_index;
    logic        last;
  } frame_word_t;

  frame_word_t expected_words[$];
  bit [7:0]    digit_font [11][5];
  bit [7:0]    frame_bytes [512];
  int          mismatches;
  int          values_seen;
  int          words_seen;
  int          text_len_hits [12];

  function new();
    // columns left to right, bit r = glyph row r; last entry is the minus sign
    digit_font = '{
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
      '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
      '{8'h62, 8'h51, 8'h49, 8'h49, 8'h46},
      '{8'h22, 8'h49, 8'h49, 8'h49, 8'h36},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
      '{8'h2F, 8'h49, 8'h49, 8'h49, 8'h31},
      '{8'h3E, 8'h49, 8'h49, 8'h49, 8'h30},
      '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
      '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
      '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}
    };
  endfunction

  task report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  // Render the decimal text of one value and queue its 64 frame words.
  function void note_input(input logic signed [31:0] value);
    bit [31:0]   raw;
    bit [31:0]   mag;
    int          rev_digits [10];
    int          codes [11];
    int          n_dig;
    int          n_chars;
    int          x0;
    int          px;
    int          py;
    bit [7:0]    bits;
    frame_word_t w;
    raw = value;
    mag = raw[31] ? (~raw + 32'd1) : raw;
    n_dig = 0;
    do begin
      rev_digits[n_dig] = mag % 10;
      mag = mag / 10;
      n_dig++;
    end while (mag != 0);
    n_chars = 0;
    if (raw[31]) begin
      codes[0] = int'(snfr_pkg::CharMinus);
      n_chars = 1;
    end
    for (int i = n_dig - 1; i >= 0; i--) begin
      codes[n_chars] = rev_digits[i];
      n_chars++;
    end
    text_len_hits[n_chars]++;
    values_seen++;

    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    x0 = (128 - (snfr_pkg::CharPitch * n_chars - 1)) / 2;
    for (int c = 0; c < n_chars; c++) begin
      for (int col = 0; col < 5; col++) begin
        bits = digit_font[codes[c]][col];
        for (int sx = 0; sx < 2; sx++) begin
          px = x0 + c * snfr_pkg::CharPitch + col * 2 + sx;
          for (int r = 0; r < 8; r++) begin
            for (int sy = 0; sy < 2; sy++) begin
              py = 8 + r * 2 + sy;
              if (bits[r] && px < 128 && py < 32)
                frame_bytes[px + (py / 8) * 128][py % 8] = 1'b1;
            end
          end
        end
      end
    end

    for (int k = 0; k < snfr_pkg::WordsOut; k++) begin
      for (int b = 0; b < 8; b++) w.pixel_word[8*b +: 8] = frame_bytes[k * 8 + b];
      w.word_index = k[5:0];
      w.last       = (k == snfr_pkg::WordsOut - 1);
      expected_words.push_back(w);
    end
  endfunction

  task check_word(input logic [63:0] pixel_word, input logic [5:0] word_index,
                  input logic last);
    frame_word_t w;
    words_seen++;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with nothing expected", word_index));
    end else begin
      w = expected_words.pop_front();
      if (pixel_word !== w.pixel_word)
        report_mismatch($sformatf("word %0d pixels %h, want %h",
                                  w.word_index, pixel_word, w.pixel_word));
      if (word_index !== w.word_index)
        report_mismatch($sformatf("word index %0d, want %0d", word_index, w.word_index));
      if (last !== w.last)
        report_mismatch($sformatf("word %0d last flag %b, want %b",
                                  w.word_index, last, w.last));
    end
  endtask
endclass

module scaled_number_framebuffer_render_tb;
  localparam int RandomValues = 90;
  localparam int HoldCycles   = 400;   // long receiver hold-off, well past one frame
  localparam int TailCycles   = 150;   // slack after the last word for stray output

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [63:0]        out_pixel_word;
  logic [5:0]         out_word_index;
  logic               out_last;

  // quiet: no random gaps on either side; hold_off_req: one-shot pressure request
  bit quiet = 1'b0;
  bit hold_off_req = 1'b0;
  int stalled_offers = 0;

  number_frame_checker frame_sb = new();

  scaled_number_framebuffer_render dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_word(out_pixel_word),
    .out_word_index(out_word_index),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one value; returns at the edge where it was taken.
  task send_value(input logic signed [31:0] value);
    int gap;
    gap = (!quiet && $urandom_range(99) < 7) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Both channels are sampled at the edge, before the block's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) frame_sb.note_input(in_value);
      if (in_valid && in_stall) stalled_offers++;
      if (out_valid && !out_stall)
        frame_sb.check_word(out_pixel_word, out_word_index, out_last);
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so the block
  // backs up and holds its input off while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (int n = 0; n < HoldCycles; n++) @(posedge clk);
      end else begin
        out_stall <= (!quiet && $urandom_range(99) < 7);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("timeout: %0d frame words still outstanding", frame_sb.expected_words.size());
    $display("[scaled_number_framebuffer_render] ERROR");
    $finish;
  end

  initial begin
    // extremes, zero, every digit and the minus glyph, text lengths 1-3, 5-7 and 9-11
    logic signed [31:0] directed_values [20] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd7, -32'sd8, 32'sd10, 32'sd42, -32'sd99,
      32'sd100, 32'sd12345, -32'sd65536, 32'sd1234567890, -32'sd1234567890,
      32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001, 32'sd1000000000,
      32'sd999999999, 32'sd3456789, -32'sd2222
    };
    logic signed [31:0] value;
    longint             lo;
    longint             hi;
    longint             mag;
    int                 ndig;
    int                 lens_hit;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) send_value(directed_values[i]);

    hold_off_req = 1'b1;
    for (int n = 0; n < RandomValues; n++) begin
      quiet = (n >= 30 && n < 60);
      if ($urandom_range(3) == 0) begin
        value = $urandom;
      end else begin
        // pick a digit count first so short and long texts are both common
        ndig = $urandom_range(1, 10);
        lo = 1;
        for (int d = 1; d < ndig; d++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag = lo + ({32'd0, $urandom} % (hi - lo + 1));
        value = 32'($urandom_range(1) ? -mag : mag);
        if (ndig == 10 && $urandom_range(15) == 0) value = 32'sh80000000;
      end
      send_value(value);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (frame_sb.expected_words.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (frame_sb.expected_words.size() != 0)
      frame_sb.report_mismatch("frame words left unmatched at the end");
    lens_hit = 0;
    for (int l = 1; l <= 11; l++) if (frame_sb.text_len_hits[l] > 0) lens_hit++;
    $display("rendered %0d values, %0d of 11 text lengths, %0d frame words compared",
             frame_sb.values_seen, lens_hit, frame_sb.words_seen);
    $display("input held back on %0d offered cycles; receiver hold-off of %0d cycles",
             stalled_offers, HoldCycles);
    if (frame_sb.mismatches == 0) begin
      $display("[scaled_number_framebuffer_render] OK");
    end else begin
      $display("[scaled_number_framebuffer_render] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/snfr_pkg.sv
rtl/scaled_number_framebuffer_render.sv
bench/scaled_number_framebuffer_render_tb.sv
